FILE: design/sfrc_pkg.sv
// Package for the sensor frame receiver: frame geometry, header bytes,
// derived widths and the controller state type. No dependencies.
package sfrc_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int FRAME_WORDS = FRAME_BYTES / 2;
  localparam int FRAME_END   = 2 * FRAME_WORDS;
  localparam int SUM_LIMIT   = FRAME_END - 2;

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 16;
  localparam int IDX_W      = 4;
  localparam int POS_W      = $clog2(FRAME_END + 1);
  localparam int ADDR_W     = $clog2(FRAME_WORDS);
  localparam int CNT_W      = $clog2(FRAME_WORDS + 1);
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [BYTE_W-1:0] HDR_HI = 8'h42;
  localparam logic [BYTE_W-1:0] HDR_LO = 8'h4D;
  localparam logic [WORD_W-1:0] HDR_WORD = {HDR_HI, HDR_LO};
  localparam logic [WORD_W-1:0] HDR_SUM  = 16'h008F;

  localparam logic [POS_W-1:0]  POS_SUM_LIMIT = POS_W'(SUM_LIMIT);
  localparam logic [POS_W-1:0]  POS_LAST      = POS_W'(FRAME_END - 1);
  localparam logic [POS_W-1:0]  POS_RESYNC    = POS_W'(2);
  localparam logic [CNT_W-1:0]  CNT_FULL      = CNT_W'(FRAME_WORDS);
  localparam logic [ADDR_W-1:0] ADDR_LAST     = ADDR_W'(FRAME_WORDS - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST      = IDX_W'(FRAME_WORDS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } rx_state_t;

endpackage

FILE: design/sfrc_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Read data holds while the port is not enabled. No dependencies.
module sfrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 12
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

FILE: design/sensor_frame_receiver_checksum.sv
// Top level of the sensor frame receiver: byte assembly, checksum and
// frame burst. Depends on sfrc_pkg and sfrc_ram (frame word store).
//
//  channel   dir  tdata (low bit up)                        tuser       tlast
//  s_*       in   rx_byte[7:0]                              -           -
//  m_*       out  word_index[3:0], word_value[19:4], pad    frame_good  last_word
//
// The byte that completes a frame starts a burst of FRAME_WORDS words read from
// the frame store, one word per cycle while the output is not stalled; then the
// controller returns to idle and the next byte can be taken. s_tready is low
// during the burst. Output stalls hold the burst; the frame-ending byte waits
// while a word is still pending at the output. Reset is synchronous; the store
// needs none.
module sensor_frame_receiver_checksum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [sfrc_pkg::IN_DATA_W-1:0]    s_tdata,   // rx_byte[7:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sfrc_pkg::OUT_DATA_W-1:0]   m_tdata,   // word_index[3:0], word_value[19:4]
  output logic                              m_tuser,   // frame_good
  output logic                              m_tlast    // last_word
);

  import sfrc_pkg::*;

  rx_state_t state, state_next;

  logic [POS_W-1:0]  pos;
  logic [BYTE_W-1:0] pair;
  logic [WORD_W-1:0] sum;
  logic              good;

  logic [CNT_W-1:0]  rd_cnt;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_idx;

  logic              m_valid;
  logic [IDX_W-1:0]  m_index;
  logic [WORD_W-1:0] m_value;
  logic              m_last;

  logic              s_accept;
  logic              odd;
  logic [ADDR_W-1:0] slot;
  logic              hdr;
  logic              end_byte;
  logic              frame_done;
  logic              adv;
  logic              issue;
  logic              ram_we;
  logic              ram_en;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_q;
  logic [WORD_W-1:0] pair_word;
  logic [WORD_W-1:0] sum_add;
  logic [ADDR_W+IDX_W-1:0] idx_wide;

  assign s_accept   = s_tvalid && s_tready;
  assign odd        = pos[0];
  assign slot       = pos[ADDR_W:1];
  assign pair_word  = {pair, s_tdata};
  assign sum_add    = sum + {{(WORD_W-BYTE_W){1'b0}}, s_tdata};
  assign hdr        = odd && (pair == HDR_HI) && (s_tdata == HDR_LO) && (slot != '0);
  assign end_byte   = (pos == POS_LAST);
  assign frame_done = s_accept && odd && !hdr && end_byte;

  assign s_tready = (state == ST_IDLE) && !(end_byte && m_valid);

  assign adv   = !m_valid || m_tready;
  assign issue = (state == ST_BURST) && (rd_cnt != CNT_FULL) && (!rd_valid || adv);

  assign ram_we    = s_accept && odd;
  assign ram_en    = ram_we || issue;
  assign ram_addr  = ram_we ? (hdr ? '0 : slot) : rd_cnt[ADDR_W-1:0];
  assign ram_wdata = hdr ? HDR_WORD : pair_word;

  sfrc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (FRAME_WORDS)
  ) u_frame_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (frame_done) begin
          state_next = ST_BURST;
        end
      end
      ST_BURST: begin
        if ((rd_cnt == CNT_FULL) && !rd_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Byte assembly and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      pair <= '0;
      sum  <= '0;
    end else if (s_accept) begin
      if (!odd) begin
        pair <= s_tdata;
        if (pos < POS_SUM_LIMIT) begin
          sum <= sum_add;
        end
        pos <= pos + POS_W'(1);
      end else if (hdr) begin
        pos <= POS_RESYNC;
        sum <= HDR_SUM;
      end else if (end_byte) begin
        pos <= '0;
        sum <= '0;
      end else begin
        if (pos < POS_SUM_LIMIT) begin
          sum <= sum_add;
        end
        pos <= pos + POS_W'(1);
      end
    end
  end

  // The checksum bytes are never summed, so the sum is final here.
  always_ff @(posedge clk) begin
    if (frame_done) begin
      good <= (pair_word == sum);
    end
  end

  // Burst read side
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt   <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (frame_done) begin
        rd_cnt <= '0;
      end else if (issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (adv) begin
        rd_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= rd_cnt[ADDR_W-1:0];
    end
  end

  assign idx_wide = {{IDX_W{1'b0}}, rd_idx};

  // Output register: advance whenever it is empty or its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rd_valid) begin
      m_index <= idx_wide[IDX_W-1:0];
      m_value <= ram_q;
      m_last  <= (rd_idx == ADDR_LAST);
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {{(OUT_DATA_W-WORD_W-IDX_W){1'b0}}, m_value, m_index};
  assign m_tuser  = good;
  assign m_tlast  = m_last;

endmodule

FILE: design/sfrc_checker.sv
// Port-level checker for the sensor frame receiver, bound to the top level.
// Depends on sfrc_pkg.
module sfrc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [sfrc_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sfrc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);

  import sfrc_pkg::*;

  logic m_accept;
  logic s_accept;

  assign m_accept = m_tvalid && m_tready;
  assign s_accept = s_tvalid && s_tready && (s_tdata == s_tdata);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] == IDX_LAST))
    else $error("last mark on wrong word index");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (m_accept && !m_tlast) |=>
      (!m_tvalid || (m_tdata[IDX_W-1:0] == IDX_W'($past(m_tdata[IDX_W-1:0]) + 1'b1))))
    else $error("word index did not advance by one");

  a_good_steady: assert property (@(posedge clk) disable iff (rst)
    (m_accept && !m_tlast) |=> (!m_tvalid || (m_tuser == $past(m_tuser))))
    else $error("frame good flag changed inside a burst");

  a_no_input_mid_burst: assert property (@(posedge clk) disable iff (rst)
    (m_accept && !m_tlast) |=> !s_accept)
    else $error("byte transfer taken inside a burst");

endmodule

bind sensor_frame_receiver_checksum sfrc_checker u_sfrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
